// ===== rtl/pba_pkg.sv =====
// Shared constants for the port bitmap allocator.
package pba_pkg;

  // Field widths
  localparam int PORT_W  = 16;
  localparam int START_W = 11;
  localparam int STAT_W  = 2;

  // Bitmap row width and bit index width inside a row
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);

  // Default sizing
  localparam int DEF_MAX_PORTS  = 2048;
  localparam int DEF_ADDR_SLOTS = 4;

  // Register reset values
  localparam logic [PORT_W-1:0] MIN_PORT_RST = 16'd11501;
  localparam logic [PORT_W-1:0] MAX_PORT_RST = 16'd12560;

  // Register indexes
  localparam logic REG_MIN_PORT = 1'b0;
  localparam logic REG_MAX_PORT = 1'b1;

  // Commands
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

// ===== rtl/pba_mod.sv =====
// Bit-serial remainder unit: start offset modulo window size.
module pba_mod
  import pba_pkg::*;
#(
  parameter int N_W = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [START_W-1:0] dvd,
  input  logic [N_W-1:0]     n,
  output logic               done,
  output logic [N_W-1:0]     rem
);

  localparam int RW    = N_W + 1;
  localparam int CW    = (N_W > START_W) ? N_W : START_W;
  localparam int CNT_W = $clog2(START_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [START_W-1:0] dvd_r;
  logic [RW-1:0]     rem_r;
  logic [N_W-1:0]    n_r;
  logic [RW-1:0]     sh;
  logic [RW-1:0]     step;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    sh   = {rem_r[RW-2:0], dvd_r[START_W-1]};
    step = (sh >= RW'(n_r)) ? (sh - RW'(n_r)) : sh;
  end

  // Control: skip the loop when the offset already lies inside the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        cnt_r <= '0;
        if (CW'(dvd) < CW'(n)) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(START_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (go) begin
      n_r   <= n;
      dvd_r <= dvd;
      if (CW'(dvd) < CW'(n)) begin
        rem_r <= RW'(dvd);
      end else begin
        rem_r <= '0;
      end
    end else if (busy_r) begin
      dvd_r <= {dvd_r[START_W-2:0], 1'b0};
      rem_r <= step;
    end
  end

  assign done = done_r;
  assign rem  = N_W'(rem_r);

endmodule

// ===== rtl/port_bitmap_allocator_top.sv =====
// Port bitmap allocator: word-wide bitmap memory with a circular free-entry scan.
//
//  channel   direction  fields
//  in_*      sink       tuser: cmd; tdata: transport, addr_slot, start_offset, release_port
//  out_*     source     tdata: port_number; tuser: status
//  cfg_*     APB slave  min_port at 0x0, max_port at 0x4
//
// An allocate is accepted, then its start index is found either directly (offset
// inside the window) or by reducing the offset bit by bit, then the 32-entry
// bitmap rows are scanned in turn, and finally the result is handed over.
// A release goes through accept, row read, row write back and result.
// The bitmap memory, with one read and one write port, sets the pace: one row read per cycle.
// After reset a clearing pass zeroes one row a cycle over all
// 2*ADDR_SLOTS*ceil(MAX_PORTS/32) rows (512 by default), while in_tready stays low.
// A stalled result register holds the sequencer in its result state, so no new item is accepted until it drains.
module port_bitmap_allocator_top
  import pba_pkg::*;
#(
  parameter int MAX_PORTS  = DEF_MAX_PORTS,
  parameter int ADDR_SLOTS = DEF_ADDR_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // transport, addr_slot[1:0], start_offset[10:0], release_port[15:0]
  input  logic        in_tuser,   // cmd
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // port_number[15:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int N_W    = $clog2(MAX_PORTS + 1);
  localparam int WORDS  = (MAX_PORTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int E_W    = WIDX_W + BIT_W;
  localparam int MAPS   = 2 * ADDR_SLOTS;
  localparam int MAP_W  = $clog2(MAPS);
  localparam int ROWS   = MAPS * WORDS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int SPAN_W = PORT_W + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_RWR  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  // Registers
  logic [2:0]          state_r, state_nxt;
  logic [ROW_W-1:0]    clr_r, clr_nxt;
  logic [PORT_W-1:0]   min_port_r, max_port_r;
  logic [MAP_W-1:0]    map_r, map_nxt;
  logic [N_W-1:0]      n_r, n_nxt;
  logic [E_W-1:0]      f_r, f_nxt;
  logic [WIDX_W-1:0]   w_r, w_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [E_W-1:0]      rel_r, rel_nxt;
  logic [PORT_W-1:0]   res_port_r, res_port_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic                out_tvalid_r;
  logic [PORT_W-1:0]   out_port_r;
  logic [STAT_W-1:0]   out_status_r;

  // Bitmap memory
  logic [WORD_W-1:0]   mem [ROWS];
  logic [WORD_W-1:0]   rdata_r;
  logic                mem_we;
  logic [ROW_W-1:0]    mem_wa;
  logic [ROW_W-1:0]    mem_ra;
  logic [WORD_W-1:0]   mem_wd;

  // Input fields
  logic                in_transport;
  logic [1:0]          in_slot;
  logic [START_W-1:0]  in_start;
  logic [PORT_W-1:0]   in_rport;
  logic                in_acc;

  // Decoded values
  logic [1:0]          slot_red;
  logic [MAP_W-1:0]    map_in;
  logic [SPAN_W-1:0]   span;
  logic [N_W-1:0]      n_w;
  logic [SPAN_W-1:0]   rel_off;
  logic                rel_ok;
  logic                mod_go;
  logic                mod_done;
  logic [N_W-1:0]      mod_rem;
  logic [N_W:0]        f_inc;
  logic [E_W-1:0]      f_new;
  logic [E_W-1:0]      nm1;
  logic [WIDX_W-1:0]   fw, lw;
  logic [WORD_W-1:0]   lo_mask, f_mask, n_mask, free_bits, pick;
  logic [BIT_W-1:0]    pick_bit;
  logic                cfg_wr;

  function automatic logic [ROW_W-1:0] row_of(input logic [MAP_W-1:0] m,
                                              input logic [WIDX_W-1:0] w);
    return ROW_W'(m) * ROW_W'(WORDS) + ROW_W'(w);
  endfunction

  assign in_transport = in_tdata[0];
  assign in_slot      = in_tdata[2:1];
  assign in_start     = in_tdata[13:3];
  assign in_rport     = in_tdata[29:14];
  assign in_tready    = (state_r == S_IDLE);
  assign in_acc       = in_tvalid && in_tready;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_port_r <= MIN_PORT_RST;
      max_port_r <= MAX_PORT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_MIN_PORT: min_port_r <= cfg_pwdata[PORT_W-1:0];
        REG_MAX_PORT: max_port_r <= cfg_pwdata[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MIN_PORT: cfg_prdata = {16'd0, min_port_r};
      REG_MAX_PORT: cfg_prdata = {16'd0, max_port_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Fold the slot into range and pick the bitmap
  always_comb begin
    slot_red = in_slot;
    for (int i = 0; i < 3; i++) begin
      if (7'(slot_red) >= 7'(ADDR_SLOTS)) begin
        slot_red = slot_red - 2'(ADDR_SLOTS);
      end
    end
    map_in = in_transport ? (MAP_W'(ADDR_SLOTS) + MAP_W'(slot_red)) : MAP_W'(slot_red);
  end

  // Window size and release range check
  always_comb begin
    span = SPAN_W'(max_port_r) - SPAN_W'(min_port_r) + SPAN_W'(1);
    if (max_port_r < min_port_r) begin
      n_w = '0;
    end else if (span > SPAN_W'(MAX_PORTS)) begin
      n_w = N_W'(MAX_PORTS);
    end else begin
      n_w = N_W'(span);
    end
    rel_off = SPAN_W'(in_rport) - SPAN_W'(min_port_r);
    rel_ok  = (n_w != '0) && (in_rport >= min_port_r) && (in_rport <= max_port_r) &&
              (rel_off < SPAN_W'(n_w));
  end

  pba_mod #(
    .N_W (N_W)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mod_go),
    .dvd   (in_start),
    .n     (n_w),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // First entry to test: one past the reduced offset, wrapping at the window end
  always_comb begin
    f_inc = (N_W + 1)'(mod_rem) + (N_W + 1)'(1);
    f_new = (f_inc == (N_W + 1)'(n_r)) ? '0 : E_W'(f_inc);
  end

  // Row masks for the scan
  always_comb begin
    nm1     = E_W'(n_r - N_W'(1));
    lw      = nm1[E_W-1:BIT_W];
    fw      = f_r[E_W-1:BIT_W];
    lo_mask = {WORD_W{1'b1}} << f_r[BIT_W-1:0];
    if (w_r == fw) begin
      f_mask = wrapped_r ? ~lo_mask : lo_mask;
    end else begin
      f_mask = {WORD_W{1'b1}};
    end
    n_mask    = (w_r == lw) ? ({WORD_W{1'b1}} >> (~nm1[BIT_W-1:0])) : {WORD_W{1'b1}};
    free_bits = ~rdata_r & f_mask & n_mask;
    pick      = free_bits & (~free_bits + WORD_W'(1));
    pick_bit  = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (pick[i]) begin
        pick_bit = pick_bit | BIT_W'(i);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    map_nxt        = map_r;
    n_nxt          = n_r;
    f_nxt          = f_r;
    w_nxt          = w_r;
    wrapped_nxt    = wrapped_r;
    rel_nxt        = rel_r;
    res_port_nxt   = res_port_r;
    res_status_nxt = res_status_r;
    mod_go         = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = row_of(map_r, w_r);
    mem_wd         = rdata_r;
    mem_ra         = row_of(map_r, w_r);
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        if (clr_r == ROW_W'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + ROW_W'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          map_nxt      = map_in;
          n_nxt        = n_w;
          res_port_nxt = '0;
          if (in_tuser == CMD_ALLOC) begin
            if (n_w == '0) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_RESP;
            end else begin
              mod_go    = 1'b1;
              state_nxt = S_MOD;
            end
          end else if (rel_ok) begin
            rel_nxt   = E_W'(rel_off);
            state_nxt = S_RRD;
          end else begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_RESP;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          f_nxt       = f_new;
          w_nxt       = f_new[E_W-1:BIT_W];
          wrapped_nxt = 1'b0;
          mem_ra      = row_of(map_r, f_new[E_W-1:BIT_W]);
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          // claim the entry and write the row back
          mem_we         = 1'b1;
          mem_wd         = rdata_r | pick;
          res_port_nxt   = min_port_r + PORT_W'({w_r, pick_bit});
          res_status_nxt = ST_DONE;
          state_nxt      = S_RESP;
        end else if (!wrapped_r && (w_r == lw)) begin
          if (f_r == '0) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            w_nxt       = '0;
            wrapped_nxt = 1'b1;
            mem_ra      = row_of(map_r, '0);
          end
        end else if (wrapped_r && (w_r == fw)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          w_nxt  = w_r + WIDX_W'(1);
          mem_ra = row_of(map_r, w_r + WIDX_W'(1));
        end
      end
      S_RRD: begin
        mem_ra    = row_of(map_r, rel_r[E_W-1:BIT_W]);
        state_nxt = S_RWR;
      end
      S_RWR: begin
        mem_we         = 1'b1;
        mem_wa         = row_of(map_r, rel_r[E_W-1:BIT_W]);
        mem_wd         = rdata_r & ~(WORD_W'(1) << rel_r[BIT_W-1:0]);
        res_status_nxt = ST_DONE;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Item context
  always_ff @(posedge clk) begin
    map_r        <= map_nxt;
    n_r          <= n_nxt;
    f_r          <= f_nxt;
    w_r          <= w_nxt;
    wrapped_r    <= wrapped_nxt;
    rel_r        <= rel_nxt;
    res_port_r   <= res_port_nxt;
    res_status_r <= res_status_nxt;
  end

  // Bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // Result register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == S_RESP) && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_RESP) && (!out_tvalid_r || out_tready)) begin
      out_port_r   <= res_port_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_port_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  // A failed item never carries a port number
  a_fail_no_port: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_DONE)) |-> (out_tdata == '0))
    else $error("failed result carries a port number");

  // The bitmap is never written while waiting for an item
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("bitmap write while idle");

  // An accepted item leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  // A claim sets exactly one new bit in the row
  a_claim_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == S_SCAN)) |-> ($countones(mem_wd) == $countones(rdata_r) + 1))
    else $error("claim changed more than one bit");
`endif

endmodule
